// ===== rtl/signed_int_to_decimal_ascii_unit_assert.svh =====
// Assertion macros for the signed integer to decimal text unit.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SIDA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sida check failed");

// Next-cycle implication, checked out of reset.
`define SIDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sida check failed");

`endif

// ===== rtl/sida_pkg.sv =====
// Shared constants and types for the signed integer to decimal text unit.
// No dependencies.
package sida_pkg;

  localparam int CHAR_W  = 6;
  localparam int DIGIT_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic done;
    logic neg;
  } sida_conv_t;

endpackage

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
// Signed integer to decimal ASCII text, top level.
// Depends on sida_pkg, sida_dabble, sida_emit and the assertion macro header.
//
// Takes one signed VALUE_BITS-bit word and sends its decimal text, most
// significant character first, one character word per handshake, with last on
// the final one: a leading '-' for negative values, no leading zeros, '0' for
// zero, and the most negative value in full. The converter runs one magnitude
// bit a cycle; the emitter then picks up the number, drops leading zero digits
// one at a time, moves on to sending and then sends the characters one by one.
// The two overlap: the next number converts while the previous text drains.
// Sustained throughput is set by the slower of the two: the converter, or the
// emitter plus any stall from the receiver.
`include "signed_int_to_decimal_ascii_unit_assert.svh"

module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        num_valid,
  output logic                        num_stall,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                        char_valid,
  input  logic                        char_stall,
  output logic [sida_pkg::CHAR_W-1:0] character,
  output logic                        last
);
  import sida_pkg::*;

  localparam int DIGITS = ((VALUE_BITS - 1) * 1233) / 4096 + 1;

  sida_conv_t               conv;
  logic [DIGITS*DIGIT_W-1:0] bcd;
  logic                     take;
  logic                     char_ok;

  assign char_ok = (character == CHAR_MINUS) ||
                   (character >= CHAR_ZERO && character <= CHAR_NINE);

  sida_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_dabble (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_stall (num_stall),
    .value     (value),
    .conv      (conv),
    .bcd       (bcd),
    .take      (take)
  );

  sida_emit #(
    .DIGITS (DIGITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .conv       (conv),
    .bcd        (bcd),
    .take       (take),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .character  (character),
    .last       (last)
  );

  `SIDA_ASSERT_NOW(a_char_range, char_valid, char_ok)
  `SIDA_ASSERT_NOW(a_minus_not_last, char_valid && character == CHAR_MINUS, !last)
  `SIDA_ASSERT_NEXT(a_handoff_holds, conv.done && !take, conv.done)
  `SIDA_ASSERT_NEXT(a_busy_after_accept, num_valid && !num_stall, num_stall)

endmodule

// ===== rtl/sida_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit a cycle.
// Depends on sida_pkg.
module sida_dabble #(
  parameter int VALUE_BITS = 32,
  parameter int DIGITS     = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   num_valid,
  output logic                                   num_stall,
  input  logic signed [VALUE_BITS-1:0]           value,
  output sida_pkg::sida_conv_t                   conv,
  output logic [DIGITS*sida_pkg::DIGIT_W-1:0]    bcd,
  input  logic                                   take
);
  import sida_pkg::*;

  localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int BW = DIGITS * DIGIT_W;

  logic                  busy;
  logic                  done;
  logic                  neg;
  logic [CW-1:0]         cnt;
  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag_next;
  logic [BW-1:0]         adj;

  assign raw      = $unsigned(value);
  assign mag_next = raw[VALUE_BITS-1] ? VALUE_BITS'(~raw + VALUE_BITS'(1)) : raw;

  for (genvar g = 0; g < DIGITS; g++) begin : g_lane
    digit_t d;
    assign d = bcd[g*DIGIT_W +: DIGIT_W];
    assign adj[g*DIGIT_W +: DIGIT_W] = (d >= DABBLE_LIMIT) ? digit_t'(d + DABBLE_ADD) : d;
  end

  assign num_stall = busy | done;
  assign conv.done = done;
  assign conv.neg  = neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (busy) begin
      bcd <= {adj[BW-2:0], mag[VALUE_BITS-1]};
      mag <= {mag[VALUE_BITS-2:0], 1'b0};
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - CW'(1);
      end
    end else if (done) begin
      if (take) begin
        done <= 1'b0;
      end
    end else if (num_valid) begin
      busy <= 1'b1;
      mag  <= mag_next;
      neg  <= raw[VALUE_BITS-1];
      bcd  <= '0;
      cnt  <= CW'(VALUE_BITS - 1);
    end
  end

endmodule

// ===== rtl/sida_emit.sv =====
// Character emitter: drops leading zeros a digit a cycle, then sends sign and digits.
// Depends on sida_pkg.
module sida_emit #(
  parameter int DIGITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sida_pkg::sida_conv_t                conv,
  input  logic [DIGITS*sida_pkg::DIGIT_W-1:0] bcd,
  output logic                                take,
  output logic                                char_valid,
  input  logic                                char_stall,
  output logic [sida_pkg::CHAR_W-1:0]         character,
  output logic                                last
);
  import sida_pkg::*;

  localparam int BW = DIGITS * DIGIT_W;
  localparam int LW = $clog2(DIGITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SKIP,
    ST_SEND
  } state_t;

  state_t        state;
  logic [BW-1:0] digs;
  logic [LW-1:0] left;
  logic          minus;
  logic          slot_free;
  digit_t        top;

  assign top       = digs[BW-1 -: DIGIT_W];
  assign slot_free = !char_valid || !char_stall;
  assign take      = (state == ST_IDLE) && conv.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
    end else begin
      if (slot_free) begin
        char_valid <= (state == ST_SEND);
      end
      case (state)
        ST_IDLE: begin
          if (conv.done) begin
            digs  <= bcd;
            left  <= LW'(DIGITS);
            minus <= conv.neg;
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (top == '0 && left > LW'(1)) begin
            digs <= {digs[BW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            left <= left - LW'(1);
          end else begin
            state <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (slot_free) begin
            if (minus) begin
              character <= CHAR_MINUS;
              last      <= 1'b0;
              minus     <= 1'b0;
            end else begin
              character <= CHAR_ZERO + CHAR_W'(top);
              last      <= (left == LW'(1));
              digs      <= {digs[BW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
              left      <= left - LW'(1);
              if (left == LW'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
